@@ sv/cpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpwm_pkg
// shared types and constants of the clamped pwm block with dead-man timeout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpwm_pkg;

  // field widths
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned PROD_W   = DUTY_W + TICK_W;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 32;

  // duty in tenths of a percent, full scale is 100%
  localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1000;

  // register reset values
  localparam logic [TICK_W-1:0] PERIOD_RESET  = 16'd100;
  localparam logic [DUTY_W-1:0] MIN_RESET     = 10'd0;
  localparam logic [DUTY_W-1:0] MAX_RESET     = 10'd1000;
  localparam logic [TICK_W-1:0] SINCE_SAT     = 16'hFFFF;

  typedef enum logic {
    MODE_TICK   = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_e;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_MIN_DUTY = 3'd1,
    REG_MAX_DUTY = 3'd2,
    REG_MIN_SNAP = 3'd3,
    REG_MAX_SNAP = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

@@ sv/cpwm_in_if.sv @@
// ----------------------------------------------------------------------------
// cpwm_in_if
// request channel: tick or duty update, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cpwm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [9:0]  duty_request;
  logic [15:0] timeout_ticks;

  modport source (output valid, output mode, output duty_request, output timeout_ticks,
                  input ready);
  modport sink   (input valid, input mode, input duty_request, input timeout_ticks,
                  output ready);
endinterface

`default_nettype wire

@@ sv/cpwm_out_if.sv @@
// ----------------------------------------------------------------------------
// cpwm_out_if
// result channel: pin level, trip flag and applied duty, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cpwm_out_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic       tripped;
  logic [9:0] duty_applied;

  modport source (output valid, output pin_level, output tripped, output duty_applied,
                  input ready);
  modport sink   (input valid, input pin_level, input tripped, input duty_applied,
                  output ready);
endinterface

`default_nettype wire

@@ sv/clamped_pwm_with_deadman_timeout.sv @@
// ----------------------------------------------------------------------------
// clamped_pwm_with_deadman_timeout
// tick-driven pwm output with duty clamping and a dead-man timeout
// ----------------------------------------------------------------------------
// Each request is a tick or a duty update and yields exactly one result in the
// cycle after it is accepted. A new request is taken in every cycle as long as the
// result register is empty or its result is taken in that same cycle, so the
// sustained rate is one request per clock. The longest path is the update: clamp,
// one 10x16 multiply of duty by period, and one compare against the phase
// threshold. Instead of storing floor(duty*period/1000) the block keeps the
// product duty*period and tests (phase+1)*1000 <= product, which is the same
// condition and needs only a constant shift-add. A timeout of 0 disables the trip;
// the elapsed-tick counter saturates at 65535. Registers sit at byte address 4*i:
// period, min duty, max duty, min-snaps-to-zero, max-snaps-to-full. Writes to
// unused addresses are ignored and read back 0. Configure only while idle.
`timescale 1ns / 1ps
`default_nettype none

module clamped_pwm_with_deadman_timeout
  import cpwm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cpwm_in_if.sink                in_i,
  cpwm_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  // configuration registers
  logic [TICK_W-1:0] period_q;
  logic [DUTY_W-1:0] min_q;
  logic [DUTY_W-1:0] max_q;
  logic              min_snap_q;
  logic              max_snap_q;

  // pwm state
  logic [DUTY_W-1:0] duty_q,    duty_d;
  logic [PROD_W-1:0] prod_q,    prod_d;     // duty * period at last update
  logic [TICK_W-1:0] phase_q,   phase_d;
  logic [TICK_W-1:0] since_q,   since_d;
  logic [TICK_W-1:0] timeout_q, timeout_d;
  logic              trip_q,    trip_d;

  // result register
  logic              out_valid_q;
  logic              pin_q,     pin_d;

  logic              in_fire;
  logic              out_fire;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  logic [DUTY_W-1:0] duty_clamp;
  logic [PROD_W-1:0] prod_new;
  logic [TICK_W:0]   phase_inc;
  logic [PROD_W:0]   phase_thr;    // (phase + 1) * 1000

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  // the result register frees up in the same cycle its result is taken
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.pin_level    = pin_q;
  assign out_o.tripped      = trip_q;
  assign out_o.duty_applied = duty_q;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_PERIOD:   prdata = CFG_DW'(period_q);
      REG_MIN_DUTY: prdata = CFG_DW'(min_q);
      REG_MAX_DUTY: prdata = CFG_DW'(max_q);
      REG_MIN_SNAP: prdata = CFG_DW'(min_snap_q);
      REG_MAX_SNAP: prdata = CFG_DW'(max_snap_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      min_q      <= MIN_RESET;
      max_q      <= MAX_RESET;
      min_snap_q <= 1'b0;
      max_snap_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PERIOD:   period_q   <= pwdata[TICK_W-1:0];
        REG_MIN_DUTY: min_q      <= pwdata[DUTY_W-1:0];
        REG_MAX_DUTY: max_q      <= pwdata[DUTY_W-1:0];
        REG_MIN_SNAP: min_snap_q <= pwdata[0];
        REG_MAX_SNAP: max_snap_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request processing
  // ---------------------------------------------------------------------------
  // min test wins when min is above max; result saturates at full scale
  always_comb begin
    duty_clamp = in_i.duty_request;
    if (in_i.duty_request < min_q) begin
      duty_clamp = min_snap_q ? '0 : min_q;
    end else if (in_i.duty_request > max_q) begin
      duty_clamp = max_snap_q ? DUTY_FULL : max_q;
    end
    if (duty_clamp > DUTY_FULL) begin
      duty_clamp = DUTY_FULL;
    end
  end

  assign prod_new  = PROD_W'(duty_clamp) * PROD_W'(period_q);
  assign phase_inc = {1'b0, phase_q} + (TICK_W+1)'(1);
  // times 1000 as 1024 - 16 - 8
  assign phase_thr = ((PROD_W+1)'(phase_inc) << 10) - ((PROD_W+1)'(phase_inc) << 4)
                   - ((PROD_W+1)'(phase_inc) << 3);

  always_comb begin
    duty_d    = duty_q;
    prod_d    = prod_q;
    phase_d   = phase_q;
    since_d   = since_q;
    timeout_d = timeout_q;
    trip_d    = trip_q;
    pin_d     = pin_q;
    if (mode_e'(in_i.mode) == MODE_UPDATE) begin
      // phase is held, not reset; pin follows the new duty at once
      duty_d    = duty_clamp;
      prod_d    = prod_new;
      timeout_d = in_i.timeout_ticks;
      since_d   = '0;
      trip_d    = 1'b0;
      pin_d     = (duty_clamp != '0) && (phase_thr <= {1'b0, prod_new});
    end else begin
      // trip once more than timeout ticks passed since the last update
      trip_d  = trip_q || ((timeout_q != '0) && (since_q >= timeout_q));
      since_d = (since_q != SINCE_SAT) ? since_q + TICK_W'(1) : since_q;
      pin_d   = !trip_d && (duty_q != '0) && (phase_thr <= {1'b0, prod_q});
      phase_d = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= '0;
      prod_q    <= '0;
      phase_q   <= '0;
      since_q   <= '0;
      timeout_q <= '0;
      trip_q    <= 1'b0;
      pin_q     <= 1'b0;
    end else if (in_fire) begin
      duty_q    <= duty_d;
      prod_q    <= prod_d;
      phase_q   <= phase_d;
      since_q   <= since_d;
      timeout_q <= timeout_d;
      trip_q    <= trip_d;
      pin_q     <= pin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_update_clears_trip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (mode_e'(in_i.mode) == MODE_UPDATE)) |=> !trip_q)
    else $error("trip flag still set after an accepted update");

  a_trip_forces_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && trip_q) |-> !pin_q)
    else $error("pin high while tripped");

  a_duty_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_FULL)
    else $error("applied duty above full scale");

  a_since_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((since_q == SINCE_SAT) && !(in_fire && (mode_e'(in_i.mode) == MODE_UPDATE)))
      |=> (since_q == SINCE_SAT))
    else $error("elapsed tick counter wrapped");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_valid_q && !out_o.ready))
    else $error("request stalled with room in the result register");
`endif

endmodule

`default_nettype wire
